// ===== rtl/triangle_geometric_factors_assert.svh =====
// assertion helpers for the triangle geometric factors block
`ifndef TRIANGLE_GEOMETRIC_FACTORS_ASSERT_SVH
`define TRIANGLE_GEOMETRIC_FACTORS_ASSERT_SVH

// same-cycle implication
`define TGF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tgf check failed");

// next-cycle implication
`define TGF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tgf check failed");

`endif

// ===== rtl/tgf_pkg.sv =====
package tgf_pkg;

    localparam int FACE_COUNT = 3;
    localparam int CW = 32;   // coordinate width
    localparam int DW = 33;   // edge difference width
    localparam int PW = 67;   // signed cross product width
    localparam int SW = 65;   // squared edge length width
    localparam int MW = 66;   // cross product magnitude width

    typedef logic [1:0] t_face;

    localparam t_face FACE_V12  = 2'd0;
    localparam t_face FACE_V23  = 2'd1;
    localparam t_face FACE_V31  = 2'd2;
    localparam t_face FACE_LAST = t_face'(FACE_COUNT - 1);

    typedef struct packed {
        t_face face;
        logic  ex_neg;
        logic  ey_neg;
        logic  s_zero;
    } t_face_side;

    typedef struct packed {
        logic [MW-1:0] pm;
        logic          pneg;
        logic          degen;
        logic [31:0]   jv;
        logic [3:0]    nneg;
    } t_vol_side;

endpackage

// ===== rtl/tgf_tri_if.sv =====
interface tgf_tri_if import tgf_pkg::*; ();
    logic valid;
    logic ready;
    logic signed [CW-1:0] vertex_x1;
    logic signed [CW-1:0] vertex_y1;
    logic signed [CW-1:0] vertex_x2;
    logic signed [CW-1:0] vertex_y2;
    logic signed [CW-1:0] vertex_x3;
    logic signed [CW-1:0] vertex_y3;

    modport source (output valid, vertex_x1, vertex_y1, vertex_x2, vertex_y2,
                    vertex_x3, vertex_y3, input ready);
    modport sink   (input valid, vertex_x1, vertex_y1, vertex_x2, vertex_y2,
                    vertex_x3, vertex_y3, output ready);
endinterface

// ===== rtl/tgf_face_if.sv =====
interface tgf_face_if import tgf_pkg::*; ();
    logic valid;
    logic ready;
    t_face face_index;
    logic signed [17:0] normal_x;
    logic signed [17:0] normal_y;
    logic [30:0] face_jacobian;
    logic [30:0] face_scale;
    logic signed [31:0] jacobian;
    logic signed [31:0] metric_rx;
    logic signed [31:0] metric_sx;
    logic signed [31:0] metric_ry;
    logic signed [31:0] metric_sy;
    logic degenerate;
    logic last_face;

    modport source (output valid, face_index, normal_x, normal_y, face_jacobian,
                    face_scale, jacobian, metric_rx, metric_sx, metric_ry, metric_sy,
                    degenerate, last_face, input ready);
    modport sink   (input valid, face_index, normal_x, normal_y, face_jacobian,
                    face_scale, jacobian, metric_rx, metric_sx, metric_ry, metric_sy,
                    degenerate, last_face, output ready);
endinterface

// ===== rtl/triangle_geometric_factors.sv =====
// each accepted triangle yields three face words, V12, V23 then V31, in order;
// a new triangle is accepted as the last face of the one before enters the pipeline
// a stall on the output freezes the whole pipeline, nothing is dropped
// reset (i_rst_n low at a clock edge) empties the pipeline; no clearing pass
`include "triangle_geometric_factors_assert.svh"

module triangle_geometric_factors import tgf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tgf_tri_if.sink      i_tri,
    tgf_face_if.source   o_face
);
    localparam int SJ_IW   = 64;
    localparam int SJ_LAT  = SJ_IW / 2 + 1;
    localparam int DIV_QW  = 32;
    localparam int DIV_LAT = DIV_QW + 1;
    localparam int U_QW    = 33;
    localparam int U_LAT   = U_QW + 1;
    localparam int U_IW    = U_QW + 1;
    localparam int UNIT_W  = U_IW / 2;
    localparam int USQ_LAT = UNIT_W + 1;
    localparam int T_END   = SJ_LAT + DIV_LAT;
    localparam int A_N     = T_END;
    localparam int B_N     = T_END - 1;
    localparam int PM_TAP  = SJ_LAT - 2;
    localparam int M_N     = T_END - 1 - DIV_LAT;
    localparam int U_N     = T_END - U_LAT - USQ_LAT;
    localparam int SJ_N    = T_END - SJ_LAT;
    localparam int JFRAC   = 18;

    function automatic logic [31:0] sat_q(logic [31:0] q, logic ovf, logic neg);
        if (neg) begin
            return (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : -q;
        end
        return (ovf || q[31]) ? 32'h7FFF_FFFF : q;
    endfunction

    function automatic logic [31:0] mag33(logic signed [DW-1:0] v);
        return v[DW-1] ? 32'(-v) : 32'(v);
    endfunction

    logic w_en;
    logic w_acc;

    // triangle holding register, feeds one face per cycle unless the output stalls
    logic signed [CW-1:0] r_x1, r_y1, r_x2, r_y2, r_x3, r_y3;
    logic  r_busy;
    t_face r_face;

    assign w_en        = !o_face.valid || o_face.ready;
    assign i_tri.ready = w_en && (!r_busy || r_face == FACE_LAST);
    assign w_acc       = i_tri.valid && i_tri.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_face <= FACE_V12;
        end else if (w_en) begin
            if (r_busy && r_face != FACE_LAST) begin
                r_face <= r_face + t_face'(1);
            end else begin
                r_face <= FACE_V12;
                r_busy <= w_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_x1 <= i_tri.vertex_x1;
            r_y1 <= i_tri.vertex_y1;
            r_x2 <= i_tri.vertex_x2;
            r_y2 <= i_tri.vertex_y2;
            r_x3 <= i_tri.vertex_x3;
            r_y3 <= i_tri.vertex_y3;
        end
    end

    // stage 1: edge differences and the face normal vector
    logic signed [DW-1:0] w_dxr, w_dxs, w_dyr, w_dys, w_ex, w_ey;
    logic signed [DW-1:0] r1_dxr, r1_dxs, r1_dyr, r1_dys, r1_ex, r1_ey;
    t_face r1_face;
    logic  r_vld1;

    always_comb begin
        w_dxr = DW'(r_x2) - DW'(r_x1);
        w_dxs = DW'(r_x3) - DW'(r_x1);
        w_dyr = DW'(r_y2) - DW'(r_y1);
        w_dys = DW'(r_y3) - DW'(r_y1);
        case (r_face)
            FACE_V12: begin
                w_ex = w_dyr;
                w_ey = -w_dxr;
            end
            FACE_V23: begin
                w_ex = DW'(r_y3) - DW'(r_y2);
                w_ey = DW'(r_x2) - DW'(r_x3);
            end
            default: begin
                w_ex = -w_dys;
                w_ey = w_dxs;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dxr  <= w_dxr;
            r1_dxs  <= w_dxs;
            r1_dyr  <= w_dyr;
            r1_dys  <= w_dys;
            r1_ex   <= w_ex;
            r1_ey   <= w_ey;
            r1_face <= r_face;
        end
    end

    // stage 2: products
    logic signed [2*DW-1:0] r2_pr1, r2_pr2;
    logic [63:0] r2_aa, r2_bb;
    logic [31:0] r2_nm [4];
    logic [3:0]  r2_nneg;
    logic        r2_exn, r2_eyn;
    t_face       r2_face;
    logic        r_vld2;
    logic [31:0] w_exm, w_eym;

    assign w_exm = mag33(r1_ex);
    assign w_eym = mag33(r1_ey);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pr1   <= r1_dxr * r1_dys;
            r2_pr2   <= r1_dxs * r1_dyr;
            r2_aa    <= w_exm * w_exm;
            r2_bb    <= w_eym * w_eym;
            // numerators of rx, sx, ry, sy: ys, -yr, -xs, xr
            r2_nm[0] <= mag33(r1_dys);
            r2_nm[1] <= mag33(r1_dyr);
            r2_nm[2] <= mag33(r1_dxs);
            r2_nm[3] <= mag33(r1_dxr);
            r2_nneg  <= {r1_dxr[DW-1],
                         !r1_dxs[DW-1] && (r1_dxs != '0),
                         !r1_dyr[DW-1] && (r1_dyr != '0),
                         r1_dys[DW-1]};
            r2_exn   <= r1_ex[DW-1];
            r2_eyn   <= r1_ey[DW-1];
            r2_face  <= r1_face;
        end
    end

    // stage 3: cross product and squared face length
    logic signed [PW-1:0] r3_p;
    logic [SW-1:0] r3_s;
    logic [63:0]   r3_aa, r3_bb;
    logic [31:0]   r3_nm [4];
    logic [3:0]    r3_nneg;
    logic          r3_exn, r3_eyn;
    t_face         r3_face;
    logic          r_vld3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_p    <= PW'(r2_pr1) - PW'(r2_pr2);
            r3_s    <= SW'(r2_aa) + SW'(r2_bb);
            r3_aa   <= r2_aa;
            r3_bb   <= r2_bb;
            r3_nm   <= r2_nm;
            r3_nneg <= r2_nneg;
            r3_exn  <= r2_exn;
            r3_eyn  <= r2_eyn;
            r3_face <= r2_face;
        end
    end

    // stage 4: magnitude of the cross product and the rounded jacobian
    logic [MW-1:0] w_pm;
    logic [MW:0]   w_jneg;
    logic [MW-1:0] w_jpos;
    logic [31:0]   w_jv;
    t_vol_side     r4_vol;
    logic [31:0]   r4_nm [4];

    always_comb begin
        w_pm   = r3_p[PW-1] ? MW'(-r3_p) : MW'(r3_p);
        w_jneg = ((MW+1)'(w_pm) + (MW+1)'({JFRAC{1'b1}})) >> JFRAC;
        w_jpos = w_pm >> JFRAC;
        if (r3_p[PW-1]) begin
            w_jv = (w_jneg > (MW+1)'(33'h0_8000_0000)) ? 32'h8000_0000 : -w_jneg[31:0];
        end else begin
            w_jv = (w_jpos > MW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : w_jpos[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_vol.pm    <= w_pm;
            r4_vol.pneg  <= r3_p[PW-1];
            r4_vol.degen <= (r3_p == '0);
            r4_vol.jv    <= w_jv;
            r4_vol.nneg  <= r3_nneg;
            r4_nm        <= r3_nm;
        end
    end

    // half face length, then sJ/J
    logic [SJ_IW/2-1:0] w_sj;
    logic [DIV_QW-1:0]  w_fq;
    logic               w_fovf;
    t_vol_side          r_b [B_N];

    tgf_isqrt #(.IW(SJ_IW)) u_sj_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (SJ_IW'(r3_s >> 2)),
        .o_root (w_sj)
    );

    tgf_div #(.NW(SJ_IW/2 + 34), .DW(MW), .QW(DIV_QW)) u_fscale_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  ({w_sj, 34'b0}),
        .i_den  (r_b[PM_TAP].pm),
        .o_quot (w_fq),
        .o_ovf  (w_fovf)
    );

    // metric terms, one divider each
    logic [DIV_QW:0] r_m [4][M_N];

    for (genvar j = 0; j < 4; j++) begin : g_metric
        logic [DIV_QW-1:0] w_q;
        logic              w_ovf;

        tgf_div #(.NW(65), .DW(MW), .QW(DIV_QW)) u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  ({r4_nm[j], 33'b0}),
            .i_den  (r4_vol.pm),
            .o_quot (w_q),
            .o_ovf  (w_ovf)
        );

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_m[j][0] <= {w_ovf, w_q};
                for (int k = 1; k < M_N; k++) begin
                    r_m[j][k] <= r_m[j][k-1];
                end
            end
        end
    end

    // unit normal components: isqrt(a^2 * 2^32 / s)
    logic [UNIT_W-1:0] r_u [2][U_N];

    for (genvar c = 0; c < 2; c++) begin : g_unit
        logic [U_QW-1:0]   w_q;
        logic              w_ovf;
        logic [UNIT_W-1:0] w_root;

        tgf_div #(.NW(96), .DW(SW), .QW(U_QW)) u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  ({(c == 0) ? r3_aa : r3_bb, 32'b0}),
            .i_den  (r3_s),
            .o_quot (w_q),
            .o_ovf  (w_ovf)
        );

        // overflow only when the face has zero length, masked at the output
        tgf_isqrt #(.IW(U_IW)) u_sqrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_val  ({w_ovf, w_q}),
            .o_root (w_root)
        );

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_u[c][0] <= w_root;
                for (int k = 1; k < U_N; k++) begin
                    r_u[c][k] <= r_u[c][k-1];
                end
            end
        end
    end

    // side data delay lines
    t_face_side         r_a   [A_N];
    logic               r_av  [A_N];
    logic [SJ_IW/2-1:0] r_sj  [SJ_N];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a[0]  <= '{face: r3_face, ex_neg: r3_exn, ey_neg: r3_eyn, s_zero: r3_s == '0};
            r_b[0]  <= r4_vol;
            r_sj[0] <= w_sj;
            for (int k = 1; k < A_N; k++) begin
                r_a[k] <= r_a[k-1];
            end
            for (int k = 1; k < B_N; k++) begin
                r_b[k] <= r_b[k-1];
            end
            for (int k = 1; k < SJ_N; k++) begin
                r_sj[k] <= r_sj[k-1];
            end
        end
    end

    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_vld3    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < A_N; k++) begin
                r_av[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld1  <= r_busy;
            r_vld2  <= r_vld1;
            r_vld3  <= r_vld2;
            r_av[0] <= r_vld3;
            for (int k = 1; k < A_N; k++) begin
                r_av[k] <= r_av[k-1];
            end
            r_out_vld <= r_av[A_N-1];
        end
    end

    // output word
    t_face_side        w_fa;
    t_vol_side         w_vb;
    logic [31:0]       w_sjf;
    logic [17:0]       w_ux, w_uy;
    t_face             r_o_face;
    logic signed [17:0] r_o_nx, r_o_ny;
    logic [30:0]       r_o_fj, r_o_fs;
    logic [31:0]       r_o_jv;
    logic [31:0]       r_o_met [4];
    logic              r_o_degen;

    assign w_fa  = r_a[A_N-1];
    assign w_vb  = r_b[B_N-1];
    assign w_sjf = r_sj[SJ_N-1];
    assign w_ux  = w_fa.s_zero ? 18'd0 : 18'(r_u[0][U_N-1]);
    assign w_uy  = w_fa.s_zero ? 18'd0 : 18'(r_u[1][U_N-1]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_face  <= w_fa.face;
            r_o_nx    <= w_fa.ex_neg ? -w_ux : w_ux;
            r_o_ny    <= w_fa.ey_neg ? -w_uy : w_uy;
            r_o_fj    <= w_sjf[31] ? 31'h7FFF_FFFF : w_sjf[30:0];
            // clockwise or flat triangles get no face scale
            r_o_fs    <= (w_vb.degen || w_vb.pneg) ? 31'd0 :
                         ((w_fovf || w_fq[31]) ? 31'h7FFF_FFFF : w_fq[30:0]);
            r_o_jv    <= w_vb.jv;
            r_o_degen <= w_vb.degen;
            for (int j = 0; j < 4; j++) begin
                r_o_met[j] <= w_vb.degen ? 32'd0 :
                              sat_q(r_m[j][M_N-1][DIV_QW-1:0], r_m[j][M_N-1][DIV_QW],
                                    w_vb.nneg[j] ^ w_vb.pneg);
            end
        end
    end

    assign o_face.valid         = r_out_vld;
    assign o_face.face_index    = r_o_face;
    assign o_face.normal_x      = r_o_nx;
    assign o_face.normal_y      = r_o_ny;
    assign o_face.face_jacobian = r_o_fj;
    assign o_face.face_scale    = r_o_fs;
    assign o_face.jacobian      = r_o_jv;
    assign o_face.metric_rx     = r_o_met[0];
    assign o_face.metric_sx     = r_o_met[1];
    assign o_face.metric_ry     = r_o_met[2];
    assign o_face.metric_sy     = r_o_met[3];
    assign o_face.degenerate    = r_o_degen;
    assign o_face.last_face     = (r_o_face == FACE_LAST);

    `TGF_ASSERT_IMP(a_face_in_range, r_busy, r_face <= FACE_LAST)
    `TGF_ASSERT_NXT(a_stall_freezes, !w_en, $stable(r_vld1) && $stable(r_face) && $stable(r_busy))
    `TGF_ASSERT_NXT(a_accept_starts, w_acc, r_busy && r_face == FACE_V12)
    `TGF_ASSERT_IMP(a_no_accept_mid, r_busy && r_face != FACE_LAST, !i_tri.ready)
    `TGF_ASSERT_IMP(a_degen_zeroes, o_face.valid && o_face.degenerate,
        o_face.jacobian == '0 && o_face.face_scale == '0 && o_face.metric_rx == '0)

endmodule

// ===== rtl/tgf_div.sv =====
module tgf_div #(
    parameter int NW = 66,
    parameter int DW = 66,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quot,
    output logic          o_ovf
);
    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic [W-1:0]  r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW+1];
    logic          r_ovf [QW+1];
    logic [W-1:0]  w_trial [QW];
    logic          w_take [QW];

    // one quotient bit per stage, msb first
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            w_trial[k] = W'(r_den[k]) << (QW - 1 - k);
            w_take[k]  = r_rem[k] >= w_trial[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= W'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= W'(i_num) >= W'({i_den, {QW{1'b0}}});
            for (int k = 1; k <= QW; k++) begin
                if (k < QW) begin
                    r_rem[k] <= w_take[k-1] ? r_rem[k-1] - w_trial[k-1] : r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                end
                r_quo[k] <= r_quo[k-1] | (w_take[k-1] ? QW'(1) << (QW - k) : QW'(0));
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quot = r_quo[QW];
    assign o_ovf  = r_ovf[QW];

endmodule

// ===== rtl/tgf_isqrt.sv =====
module tgf_isqrt #(
    parameter int IW = 64
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [IW-1:0]   i_val,
    output logic [IW/2-1:0] o_root
);
    localparam int RW = IW / 2;

    logic [IW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW+1];
    logic [IW-1:0] w_term [RW];
    logic          w_take [RW];

    // rem holds x - root^2; adding bit b grows root^2 by root*2^(b+1) + 4^b
    always_comb begin
        for (int k = 0; k < RW; k++) begin
            w_term[k] = (IW'(r_root[k]) << (RW - k)) | (IW'(1) << (2 * (RW - 1 - k)));
            w_take[k] = r_rem[k] >= w_term[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_val;
            r_root[0] <= '0;
            for (int k = 1; k <= RW; k++) begin
                if (k < RW) begin
                    r_rem[k] <= w_take[k-1] ? r_rem[k-1] - w_term[k-1] : r_rem[k-1];
                end
                r_root[k] <= r_root[k-1] | (w_take[k-1] ? RW'(1) << (RW - k) : RW'(0));
            end
        end
    end

    assign o_root = r_root[RW];

endmodule

// ===== sim/triangle_geometric_factors_tb.sv =====
`timescale 1ns / 1ps

module triangle_geometric_factors_tb;
    import tgf_pkg::*;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
    localparam int RANDOM_TRIS = 120;
    localparam int DRAIN_CYCLES = 90;

    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [31:0] x3;
        logic signed [31:0] y3;
    } t_tri;

    typedef struct packed {
        t_face              face;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic [30:0]        face_jac;
        logic [30:0]        face_scale;
        logic signed [31:0] jac;
        logic signed [31:0] rx;
        logic signed [31:0] sx;
        logic signed [31:0] ry;
        logic signed [31:0] sy;
        logic               degen;
        logic               last;
    } t_face_word;

    logic i_clk;
    logic i_rst_n;

    tgf_tri_if  tri_bus ();
    tgf_face_if face_bus ();

    triangle_geometric_factors DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tri  (tri_bus.sink),
        .o_face (face_bus.source)
    );

    t_face_word expected_faces[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("[triangle_geometric_factors] ERROR");
        $finish;
    end

    // ---------------- face factor predictor ----------------

    function automatic logic signed [31:0] sat_signed32(logic [127:0] mag, logic neg);
        if (neg) begin
            if (mag > 128'h8000_0000) return C_MIN;
            return -$signed(mag[31:0]);
        end
        if (mag > 128'h7FFF_FFFF) return C_MAX;
        return mag[31:0];
    endfunction

    function automatic logic [127:0] mag128(logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    // trunc(num * 2^33 / p), saturated
    function automatic logic signed [31:0] metric_quot(logic signed [127:0] num,
                                                       logic signed [127:0] p);
        logic [127:0] q;
        q = (mag128(num) << 33) / mag128(p);
        return sat_signed32(q, (num < 0) != (p < 0));
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'h1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // largest m <= 65536 with m*m*s <= a*a*2^32, sign of a
    function automatic logic signed [17:0] unit_component(logic signed [127:0] a,
                                                          logic [127:0] s);
        logic [127:0] target;
        logic [127:0] m;
        logic [127:0] t;
        target = (mag128(a) * mag128(a)) << 32;
        m = 0;
        for (int b = 16; b >= 0; b--) begin
            t = m | (128'h1 << b);
            if (t <= 65536 && target >= t * t * s) m = t;
        end
        return a < 0 ? -$signed(m[17:0]) : m[17:0];
    endfunction

    function automatic void queue_face_words(t_tri t);
        logic signed [127:0] dxr, dxs, dyr, dys, p;
        logic signed [127:0] ex[3], ey[3];
        logic [127:0] s, quo;
        logic [63:0] sj;
        t_face_word w;
        dxr = t.x2 - t.x1;
        dxs = t.x3 - t.x1;
        dyr = t.y2 - t.y1;
        dys = t.y3 - t.y1;
        p = dxr * dys - dxs * dyr;
        w = '0;
        w.degen = (p == 0);
        if (!w.degen) begin
            if (p < 0) w.jac = sat_signed32((mag128(p) + 128'h3FFFF) >> 18, 1'b1);
            else w.jac = sat_signed32(p >> 18, 1'b0);
            w.rx = metric_quot(dys, p);
            w.sx = metric_quot(-dyr, p);
            w.ry = metric_quot(-dxs, p);
            w.sy = metric_quot(dxr, p);
        end
        ex[0] = dyr;                   ey[0] = -dxr;
        ex[1] = t.y3 - t.y2;           ey[1] = t.x2 - t.x3;
        ex[2] = -dys;                  ey[2] = dxs;
        for (int f = 0; f < FACE_COUNT; f++) begin
            s = mag128(ex[f]) * mag128(ex[f]) + mag128(ey[f]) * mag128(ey[f]);
            sj = floor_sqrt(s[65:2]);
            w.face = t_face'(f);
            w.last = (w.face == FACE_LAST);
            w.nx = (s == 0) ? '0 : unit_component(ex[f], s);
            w.ny = (s == 0) ? '0 : unit_component(ey[f], s);
            w.face_jac = (sj > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sj[30:0];
            w.face_scale = '0;
            if (!w.degen && p > 0) begin
                quo = ({64'h0, sj} << 34) / p;
                w.face_scale = (quo > 128'h7FFF_FFFF) ? 31'h7FFF_FFFF : quo[30:0];
            end
            expected_faces.push_back(w);
        end
    endfunction

    // ---------------- result side ----------------

    always @(posedge i_clk) begin
        t_face_word got;
        t_face_word want;
        if (!i_rst_n) begin
            face_bus.ready <= 1'b0;
        end else begin
            face_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (face_bus.valid && face_bus.ready) begin
                got = '{face_bus.face_index, face_bus.normal_x, face_bus.normal_y,
                        face_bus.face_jacobian, face_bus.face_scale, face_bus.jacobian,
                        face_bus.metric_rx, face_bus.metric_sx, face_bus.metric_ry,
                        face_bus.metric_sy, face_bus.degenerate, face_bus.last_face};
                if (expected_faces.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected face word %p", got);
                end else begin
                    want = expected_faces.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("face word mismatch\n  exp %p\n  got %p", want, got);
                    end
                end
            end
        end
    end

    // ---------------- triangle side ----------------

    task automatic send_triangle(t_tri t);
        while ($urandom_range(99) < send_idle_pct) begin
            tri_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        tri_bus.valid     <= 1'b1;
        tri_bus.vertex_x1 <= t.x1;
        tri_bus.vertex_y1 <= t.y1;
        tri_bus.vertex_x2 <= t.x2;
        tri_bus.vertex_y2 <= t.y2;
        tri_bus.vertex_x3 <= t.x3;
        tri_bus.vertex_y3 <= t.y3;
        do @(posedge i_clk); while (!tri_bus.ready);
        queue_face_words(t);
    endtask

    function automatic logic signed [31:0] pick_coord(int span);
        case ($urandom_range(3))
            0: return C_MIN;
            1: return C_MAX;
            2: return $urandom_range(2 * span) - span;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_tri random_triangle();
        t_tri t;
        logic signed [31:0] dx, dy;
        int k;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                t = '{$urandom_range(1 << 22) - (1 << 21), $urandom_range(1 << 22) - (1 << 21),
                      $urandom_range(1 << 22) - (1 << 21), $urandom_range(1 << 22) - (1 << 21),
                      $urandom_range(1 << 22) - (1 << 21), $urandom_range(1 << 22) - (1 << 21)};
            end
            4, 5: t = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            6: begin
                // collinear vertices, zero area
                dx = $urandom_range(1 << 18) - (1 << 17);
                dy = $urandom_range(1 << 18) - (1 << 17);
                k = $urandom_range(6) - 3;
                t.x1 = $urandom_range(1 << 24) - (1 << 23);
                t.y1 = $urandom_range(1 << 24) - (1 << 23);
                t.x2 = t.x1 + dx;
                t.y2 = t.y1 + dy;
                t.x3 = t.x1 + k * dx;
                t.y3 = t.y1 + k * dy;
            end
            7: begin
                t = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                if ($urandom_range(1)) begin
                    t.x3 = t.x2;
                    t.y3 = t.y2;
                end else begin
                    t.x2 = t.x1;
                    t.y2 = t.y1;
                end
            end
            8: t = '{pick_coord(1 << 20), pick_coord(1 << 20), pick_coord(1 << 20),
                     pick_coord(1 << 20), pick_coord(1 << 20), pick_coord(1 << 20)};
            default: begin
                // tiny area, jacobian rounds away
                t = '{$urandom_range(8) - 4, $urandom_range(8) - 4, $urandom_range(8) - 4,
                      $urandom_range(8) - 4, $urandom_range(8) - 4, $urandom_range(8) - 4};
            end
        endcase
        return t;
    endfunction

    t_tri corner_tris [14];

    initial begin
        tri_bus.valid     <= 1'b0;
        tri_bus.vertex_x1 <= '0;
        tri_bus.vertex_y1 <= '0;
        tri_bus.vertex_x2 <= '0;
        tri_bus.vertex_y2 <= '0;
        tri_bus.vertex_x3 <= '0;
        tri_bus.vertex_y3 <= '0;
        i_rst_n <= 1'b0;
        corner_tris = '{
            '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{32'sd0, 32'sd0, Q_ONE, 32'sd0, 32'sd0, Q_ONE},
            '{32'sd0, 32'sd0, 32'sd0, Q_ONE, Q_ONE, 32'sd0},
            '{-Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, Q_ONE},
            '{C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX},
            '{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN},
            '{C_MIN, C_MIN, C_MAX, C_MAX, 32'sd0, 32'sd0},
            '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX},
            '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN},
            '{Q_ONE, Q_ONE, Q_ONE, Q_ONE, 32'sd0, Q_ONE},
            '{32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd1},
            '{32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA,
              32'shAAAA_AAAA, 32'shAAAA_AAAA},
            '{32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
              32'sh5555_5555, 32'sh5555_5555},
            '{32'sd0, 32'sd0, 32'sd1, 32'sd0, C_MAX, C_MAX}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 9;
        recv_idle_pct = 72;
        foreach (corner_tris[i]) send_triangle(corner_tris[i]);
        for (int i = 0; i < RANDOM_TRIS / 3; i++) send_triangle(random_triangle());

        // hold off until the pipeline has drained
        tri_bus.valid <= 1'b0;
        while (expected_faces.size() != 0) @(posedge i_clk);

        send_idle_pct = 72;
        recv_idle_pct = 9;
        for (int i = 0; i < RANDOM_TRIS / 3; i++) send_triangle(random_triangle());
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < RANDOM_TRIS / 3; i++) send_triangle(random_triangle());
        tri_bus.valid <= 1'b0;

        while (expected_faces.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_faces.size() == 0) begin
            $display("[triangle_geometric_factors] OK");
        end else begin
            $display("[triangle_geometric_factors] ERROR");
        end
        $finish;
    end

endmodule
